// ----- rtl/core/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal heading controller
// Fixed-point widths, register indexes, finish reasons, the arctangent table
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gtg_pkg;

	localparam int XW = 34;   // CORDIC x/y width, Q6.24 plus growth
	localparam int ZW = 28;   // CORDIC angle width, units of 2^-24 rad
	localparam int DW = 20;   // distance width, signed Q6.10
	localparam int BW = 17;   // bearing width, signed Q3.13
	localparam int EW = 18;   // heading error width, signed Q3.13

	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic [15:0] GAIN_Q16 = 16'd39797;
	localparam int PRESHIFT = 14;
	localparam logic signed [EW-1:0] ANG_PI_Q13  = 18'sd25736;
	localparam logic signed [EW-1:0] ANG_2PI_Q13 = 18'sd51472;

	localparam logic [2:0] REG_TURN_GAIN    = 3'd0;
	localparam logic [2:0] REG_DRIVE_GAIN   = 3'd1;
	localparam logic [2:0] REG_ARRIVE_TOL   = 3'd2;
	localparam logic [2:0] REG_HEADING_TOL  = 3'd3;
	localparam logic [2:0] REG_LINEAR_LIMIT = 3'd4;
	localparam logic [2:0] REG_ANGULAR_LIM  = 3'd5;
	localparam logic [2:0] REG_TICK_LIMIT   = 3'd6;

	localparam logic [1:0] REASON_NONE    = 2'd0;
	localparam logic [1:0] REASON_ARRIVED = 2'd1;
	localparam logic [1:0] REASON_TIMEOUT = 2'd2;

	typedef struct packed {
		logic load;
		logic rotate;
		logic measure;
		logic err;
		logic cmd;
		logic publish;
	} gtg_cmd_t;

	typedef struct packed {
		logic last_step;
	} gtg_stat_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:  v = 28'sd13176795;
			5'd1:  v = 28'sd7778716;
			5'd2:  v = 28'sd4110060;
			5'd3:  v = 28'sd2086331;
			5'd4:  v = 28'sd1047214;
			5'd5:  v = 28'sd524117;
			5'd6:  v = 28'sd262123;
			5'd7:  v = 28'sd131069;
			5'd8:  v = 28'sd65536;
			5'd9:  v = 28'sd32768;
			5'd10: v = 28'sd16384;
			5'd11: v = 28'sd8192;
			5'd12: v = 28'sd4096;
			5'd13: v = 28'sd2048;
			5'd14: v = 28'sd1024;
			5'd15: v = 28'sd512;
			5'd16: v = 28'sd256;
			5'd17: v = 28'sd128;
			5'd18: v = 28'sd64;
			5'd19: v = 28'sd32;
			5'd20: v = 28'sd16;
			5'd21: v = 28'sd8;
			5'd22: v = 28'sd4;
			5'd23: v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/gtg_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtg_ctrl: sequencer of the go-to-goal heading controller
// Steps one request through load, CORDIC iterations, distance, error,
// command and publish, and owns the handshake flags.
// ----------------------------------------------------------------------------
module gtg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  gtg_pkg::gtg_stat_t stat,
	output gtg_pkg::gtg_cmd_t  cmd
);
	import gtg_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_DIST = 3'd2;
	localparam logic [2:0] ST_ERR  = 3'd3;
	localparam logic [2:0] ST_CMD  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ROT;
				end
			end
			ST_ROT: begin
				cmd.rotate = 1'b1;
				if (stat.last_step) begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.measure = 1'b1;
				state_d     = ST_ERR;
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				state_d = ST_CMD;
			end
			ST_CMD: begin
				cmd.cmd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/gtg_datapath.sv -----
// ----------------------------------------------------------------------------
// gtg_datapath: arithmetic and state of the go-to-goal heading controller
// Holds the configuration, the serial vectoring CORDIC, the heading error
// wrap, the proportional commands with saturation and the move state.
// ----------------------------------------------------------------------------
module gtg_datapath #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic               new_target,
	input  gtg_pkg::gtg_cmd_t  cmd,
	output gtg_pkg::gtg_stat_t stat,
	output logic [14:0]        linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic               finished,
	output logic [1:0]         finish_reason
);
	import gtg_pkg::*;

	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// Configuration registers.
	logic [15:0] turn_gain_q, drive_gain_q, tick_limit_q;
	logic [14:0] arrive_tol_q, heading_tol_q, linear_limit_q, angular_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q     <= 16'd2048;
			drive_gain_q    <= 16'd3277;
			arrive_tol_q    <= 15'd102;
			heading_tol_q   <= 15'd819;
			linear_limit_q  <= 15'd1024;
			angular_limit_q <= 15'd8192;
			tick_limit_q    <= 16'd300;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TURN_GAIN:    turn_gain_q     <= cfg_data;
				REG_DRIVE_GAIN:   drive_gain_q    <= cfg_data;
				REG_ARRIVE_TOL:   arrive_tol_q    <= cfg_data[14:0];
				REG_HEADING_TOL:  heading_tol_q   <= cfg_data[14:0];
				REG_LINEAR_LIMIT: linear_limit_q  <= cfg_data[14:0];
				REG_ANGULAR_LIM:  angular_limit_q <= cfg_data[14:0];
				REG_TICK_LIMIT:   tick_limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load and pre-rotation into the right half plane.
	logic signed [16:0] dx, dy;
	logic signed [XW-1:0] x0, y0;
	assign dx = 17'(target_x) - 17'(pose_x);
	assign dy = 17'(target_y) - 17'(pose_y);
	assign x0 = XW'(dx) <<< PRESHIFT;
	assign y0 = XW'(dy) <<< PRESHIFT;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [SW-1:0]        step_q;
	logic                 zero_q;
	logic signed [15:0]   hd_q;

	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = atan_q24(5'(step_q));
	assign stat.last_step = (step_q == SW'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_q <= '0;
			zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
			hd_q   <= pose_heading;
			if (dx < 0) begin
				if (dy >= 0) begin
					x_q <= y0;
					y_q <= -x0;
					z_q <= HALF_PI_Q24;
				end else begin
					x_q <= -y0;
					y_q <= x0;
					z_q <= -HALF_PI_Q24;
				end
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (cmd.rotate) begin
			step_q <= step_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	// Distance scaling and bearing rounding.
	logic signed [XW+16:0] dist_prod;
	logic signed [ZW-1:0]  z_rnd;
	logic signed [DW-1:0]  dist_q;
	logic signed [BW-1:0]  bear_q;
	assign dist_prod = x_q * $signed({1'b0, GAIN_Q16});
	assign z_rnd     = z_q + ZW'(1024);

	always_ff @(posedge clk) begin
		if (cmd.measure) begin
			if (zero_q) begin
				dist_q <= '0;
				bear_q <= '0;
			end else begin
				dist_q <= DW'((dist_prod + (XW+17)'(64'd1 << 29)) >>> 30);
				bear_q <= BW'(z_rnd >>> 11);
			end
		end
	end

	// Heading error wrapped into plus or minus pi.
	logic signed [EW-1:0] err_raw, err_wrap, err_abs, err_q;
	logic                 turn_q;
	always_comb begin
		err_raw = EW'(bear_q) - EW'(hd_q);
		if (err_raw > ANG_PI_Q13) begin
			err_wrap = err_raw - ANG_2PI_Q13;
		end else if (err_raw < -ANG_PI_Q13) begin
			err_wrap = err_raw + ANG_2PI_Q13;
		end else begin
			err_wrap = err_raw;
		end
		err_abs = (err_wrap < 0) ? -err_wrap : err_wrap;
	end

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			err_q  <= err_wrap;
			turn_q <= err_abs > $signed({3'b000, heading_tol_q});
		end
	end

	// Proportional commands with saturation.
	logic signed [34:0] ang_prod, ang_shift, ang_lim;
	logic signed [36:0] lin_prod, lin_shift, lin_lim;
	logic signed [15:0] ang_sat;
	logic [14:0]        lin_sat;
	always_comb begin
		ang_prod  = $signed({1'b0, turn_gain_q}) * err_q;
		ang_shift = (ang_prod + 35'sd2048) >>> 12;
		ang_lim   = $signed({20'd0, angular_limit_q});
		if (ang_shift > ang_lim) begin
			ang_sat = 16'(ang_lim);
		end else if (ang_shift < -ang_lim) begin
			ang_sat = 16'(-ang_lim);
		end else begin
			ang_sat = 16'(ang_shift);
		end
		lin_prod  = $signed({1'b0, drive_gain_q}) * dist_q;
		lin_shift = (lin_prod + 37'sd2048) >>> 12;
		lin_lim   = $signed({22'd0, linear_limit_q});
		lin_sat   = (lin_shift > lin_lim) ? linear_limit_q : 15'(lin_shift);
	end

	// Move state and result registers.
	logic [15:0]        tick_q;
	logic               over_q;
	logic [14:0]        lin_q;
	logic signed [15:0] ang_q;
	logic               fin_q;
	logic [1:0]         reason_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			over_q <= 1'b0;
		end else if (cmd.load && new_target) begin
			tick_q <= '0;
			over_q <= 1'b0;
		end else if (cmd.cmd && !over_q) begin
			if (tick_q >= tick_limit_q) begin
				over_q <= 1'b1;
			end else if (dist_q < $signed({5'd0, arrive_tol_q})) begin
				over_q <= 1'b1;
			end else if (tick_q != 16'hFFFF) begin
				tick_q <= tick_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmd) begin
			lin_q    <= '0;
			ang_q    <= '0;
			fin_q    <= 1'b0;
			reason_q <= REASON_NONE;
			if (!over_q) begin
				if (tick_q >= tick_limit_q) begin
					fin_q    <= 1'b1;
					reason_q <= REASON_TIMEOUT;
				end else if (dist_q < $signed({5'd0, arrive_tol_q})) begin
					fin_q    <= 1'b1;
					reason_q <= REASON_ARRIVED;
				end else if (turn_q) begin
					ang_q <= ang_sat;
				end else begin
					lin_q <= lin_sat;
				end
			end
		end
		if (cmd.publish) begin
			linear_cmd    <= lin_q;
			angular_cmd   <= ang_q;
			finished      <= fin_q;
			finish_reason <= reason_q;
		end
	end

endmodule

// ----- rtl/core/go_to_goal_heading_controller_top.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_top: proportional go-to-goal controller
// Takes a target point and a measured pose each control tick and returns a
// saturated forward speed and turn rate, or a zero command with a reason.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Contents
//   in       sink       in_valid / in_stall  target, pose, heading, new_target
//   out      source     out_valid/out_stall  linear/angular command, finish
//   cfg      sink       cfg_write            cfg_index, cfg_data (7 registers)
//
// A request passes from acceptance through the load, the serial CORDIC,
// which runs one micro-rotation per cycle on a single shift-add unit, and
// the distance, error and command steps to the publish. No new request is
// taken before then; the next one is accepted in the cycle after the publish.
// Reset clears the sequencer, the output valid flag, the tick counter and
// the move-over flag, and loads the configuration defaults.
// A finished result waits in the output register while the next request is
// accepted and computed; only the final publish waits for the output side.
module go_to_goal_heading_controller_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic               new_target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic               finished,
	output logic [1:0]         finish_reason
);
	import gtg_pkg::*;

	// Command bundle from the sequencer and status back from the datapath.
	gtg_cmd_t  cmd;
	gtg_stat_t stat;

	gtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath also owns the configuration registers and move state.
	gtg_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.target_x      (target_x),
		.target_y      (target_y),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.pose_heading  (pose_heading),
		.new_target    (new_target),
		.cmd           (cmd),
		.stat          (stat),
		.linear_cmd    (linear_cmd),
		.angular_cmd   (angular_cmd),
		.finished      (finished),
		.finish_reason (finish_reason)
	);

	// An accepted request blocks the input until its result is published.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting a request");

	// A finishing tick always carries a zero command.
	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> (linear_cmd == 15'd0 && angular_cmd == 16'sd0))
		else $error("nonzero command on a finishing tick");

	// The finish flag and the reason code agree.
	a_reason_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == (finish_reason != REASON_NONE)))
		else $error("finish flag and reason disagree");

endmodule

// ----- verif/go_to_goal_heading_controller_top_tb.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_top_tb: regression for the go-to-goal block
// Drives control-tick requests through the valid/stall input channel, predicts
// each command with an independent fixed-point model of the controller, and
// compares every result field by field. Directed tests cover the field
// extremes, zero offset, arrival, the tick limit and register extremes.
// Random phases then run goal sequences under changing settings and idling.
// ----------------------------------------------------------------------------
module go_to_goal_heading_controller_top_tb;
	import gtg_pkg::*;

	localparam int NUM_STEPS = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = NUM_STEPS + 24;

	typedef struct {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
		logic               nt;
	} tick_req_t;

	typedef struct {
		logic [14:0]        lin;
		logic signed [15:0] ang;
		logic               fin;
		logic [1:0]         reason;
	} motion_cmd_t;

	// Arctangent of 2^-i in units of 2^-24 rad.
	longint arctan_steps [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic signed [15:0] pose_x;
	logic signed [15:0] pose_y;
	logic signed [15:0] pose_heading;
	logic               new_target;
	logic               out_valid;
	logic               out_stall;
	logic [14:0]        linear_cmd;
	logic signed [15:0] angular_cmd;
	logic               finished;
	logic [1:0]         finish_reason;

	go_to_goal_heading_controller_top #(.CORDIC_STEPS(NUM_STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_x(target_x), .target_y(target_y),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.new_target(new_target),
		.out_valid(out_valid), .out_stall(out_stall),
		.linear_cmd(linear_cmd), .angular_cmd(angular_cmd),
		.finished(finished), .finish_reason(finish_reason)
	);

	// Shadow of the register file and of the controller state.
	logic [15:0] shadow_regs [7];
	logic [15:0] ticks_used;
	logic        goal_closed;

	motion_cmd_t pending_cmds [$];
	int          mismatch_count;
	int          cycle_count;
	int          burst_left;
	int          stall_mode;
	int          stall_phase;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Distance (Q6.10) and bearing (Q3.13) to the goal by vectoring CORDIC.
	task automatic locate_goal(input longint dx, input longint dy,
			output longint goal_dist, output longint bear);
		longint x, y, z, t, xs, ys;
		x = dx <<< PRESHIFT;
		y = dy <<< PRESHIFT;
		z = 0;
		if (dx == 0 && dy == 0) begin
			goal_dist = 0;
			bear = 0;
			return;
		end
		// Fold the left half plane onto the right one first.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q24;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q24;
			end
		end
		for (int i = 0; i < NUM_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_steps[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_steps[i];
			end
		end
		goal_dist = (x * 39797 + (64'sd1 <<< 29)) >>> 30;
		bear = (z + 1024) >>> 11;
	endtask

	// Works out the command of one tick and advances the shadow state.
	task automatic predict_command(input tick_req_t rq, output motion_cmd_t cmd);
		longint goal_dist, bear, err, ang, lin;
		ang = 0;
		lin = 0;
		cmd.fin = 1'b0;
		cmd.reason = REASON_NONE;
		if (rq.nt) begin
			ticks_used = '0;
			goal_closed = 1'b0;
		end
		if (!goal_closed) begin
			locate_goal(longint'(rq.tx) - longint'(rq.px),
				longint'(rq.ty) - longint'(rq.py), goal_dist, bear);
			if (ticks_used >= shadow_regs[REG_TICK_LIMIT]) begin
				cmd.fin = 1'b1;
				cmd.reason = REASON_TIMEOUT;
				goal_closed = 1'b1;
			end else if (goal_dist < longint'(shadow_regs[REG_ARRIVE_TOL])) begin
				cmd.fin = 1'b1;
				cmd.reason = REASON_ARRIVED;
				goal_closed = 1'b1;
			end else begin
				err = bear - longint'(rq.hd);
				while (err > 25736) err = err - 51472;
				while (err < -25736) err = err + 51472;
				if ((err < 0 ? -err : err) > longint'(shadow_regs[REG_HEADING_TOL])) begin
					ang = (longint'(shadow_regs[REG_TURN_GAIN]) * err + 2048) >>> 12;
					if (ang > longint'(shadow_regs[REG_ANGULAR_LIM]))
						ang = shadow_regs[REG_ANGULAR_LIM];
					if (ang < -longint'(shadow_regs[REG_ANGULAR_LIM]))
						ang = -longint'(shadow_regs[REG_ANGULAR_LIM]);
				end else begin
					lin = (longint'(shadow_regs[REG_DRIVE_GAIN]) * goal_dist + 2048) >>> 12;
					if (lin > longint'(shadow_regs[REG_LINEAR_LIMIT]))
						lin = shadow_regs[REG_LINEAR_LIMIT];
				end
				if (ticks_used != 16'hFFFF) ticks_used = ticks_used + 1'b1;
			end
		end
		cmd.lin = lin[14:0];
		cmd.ang = ang[15:0];
	endtask

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
			what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// Sends one tick request, records its prediction on acceptance, and then
	// either holds valid for the next request of the burst or opens a gap.
	task automatic send_tick(input tick_req_t rq);
		motion_cmd_t cmd;
		@(negedge clk);
		in_valid = 1'b1;
		target_x = rq.tx;
		target_y = rq.ty;
		pose_x = rq.px;
		pose_y = rq.py;
		pose_heading = rq.hd;
		new_target = rq.nt;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_command(rq, cmd);
		pending_cmds.push_back(cmd);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(40)) @(negedge clk);
			burst_left = $urandom_range(3) == 0 ? $urandom_range(30) : $urandom_range(4);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only while nothing is in flight.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		shadow_regs[idx] = (idx == REG_TURN_GAIN || idx == REG_DRIVE_GAIN ||
			idx == REG_TICK_LIMIT) ? value : {1'b0, value[14:0]};
	endtask

	function automatic tick_req_t make_tick(input int tx, input int ty, input int px,
			input int py, input int hd, input logic nt);
		tick_req_t rq;
		rq.tx = tx[15:0];
		rq.ty = ty[15:0];
		rq.px = px[15:0];
		rq.py = py[15:0];
		rq.hd = hd[15:0];
		rq.nt = nt;
		return rq;
	endfunction

	function automatic int rand_heading();
		return int'($urandom_range(51472)) - 25736;
	endfunction

	// Field extremes, the zero offset, arrival and each quadrant.
	task automatic test_field_extremes();
		send_tick(make_tick(0, 0, 0, 0, 0, 1'b1));
		send_tick(make_tick(32767, 32767, -32768, -32768, 25736, 1'b1));
		send_tick(make_tick(-32768, -32768, 32767, 32767, -25736, 1'b1));
		send_tick(make_tick(-32768, 32767, 32767, -32768, 0, 1'b1));
		send_tick(make_tick(32767, -32768, -32768, 32767, 12868, 1'b1));
		send_tick(make_tick(5000, 0, 0, 0, 0, 1'b1));
		send_tick(make_tick(-5000, 0, 0, 0, 0, 1'b1));
		send_tick(make_tick(-5000, -1, 0, 0, 25736, 1'b1));
		send_tick(make_tick(0, 5000, 0, 0, -25736, 1'b1));
		send_tick(make_tick(0, -5000, 0, 0, 100, 1'b1));
		send_tick(make_tick(1000, 1000, 950, 990, 0, 1'b1));
		send_tick(make_tick(1000, 1000, 1000, 1000, 0, 1'b0));
		send_tick(make_tick(3000, 20, 0, 0, 0, 1'b0));
		send_tick(make_tick(3000, 20, 0, 0, 0, 1'b1));
		wait_drained();
	endtask

	// Tick limit of zero ends every move at once; a small limit runs out.
	task automatic test_tick_limit();
		write_reg(REG_TICK_LIMIT, 16'd0);
		send_tick(make_tick(8000, 8000, 0, 0, 0, 1'b1));
		send_tick(make_tick(8000, 8000, 0, 0, 0, 1'b0));
		wait_drained();
		write_reg(REG_TICK_LIMIT, 16'd3);
		for (int k = 0; k < 6; k++)
			send_tick(make_tick(8000, -8000, 0, 0, 9000, k == 0));
		send_tick(make_tick(8000, 8000, 8000, 8000, 0, 1'b1));
		wait_drained();
		write_reg(REG_TICK_LIMIT, 16'hFFFF);
	endtask

	// Register extremes: zero and full-scale gains, limits and tolerances.
	task automatic test_register_extremes();
		for (int pass = 0; pass < 2; pass++) begin
			write_reg(REG_TURN_GAIN, pass ? 16'hFFFF : 16'h0000);
			write_reg(REG_DRIVE_GAIN, pass ? 16'hFFFF : 16'h0000);
			write_reg(REG_ARRIVE_TOL, pass ? 16'h0000 : 16'h7FFF);
			write_reg(REG_HEADING_TOL, pass ? 16'd25736 : 16'd0);
			write_reg(REG_LINEAR_LIMIT, pass ? 16'h7FFF : 16'h0000);
			write_reg(REG_ANGULAR_LIM, pass ? 16'h7FFF : 16'h0000);
			send_tick(make_tick(20000, 20000, -10000, -10000, -20000, 1'b1));
			send_tick(make_tick(-30000, 100, 30000, 0, 20000, 1'b1));
			send_tick(make_tick(1, 0, 0, 0, 0, 1'b1));
			wait_drained();
		end
	endtask

	function automatic logic [15:0] rand_reg(input logic [2:0] idx);
		int top;
		case (idx)
			REG_TURN_GAIN, REG_DRIVE_GAIN: top = 65535;
			REG_HEADING_TOL: top = 25736;
			REG_TICK_LIMIT: top = 65535;
			default: top = 32767;
		endcase
		case ($urandom_range(4))
			0: return 16'd0;
			1: return top[15:0];
			default: begin
				if (idx == REG_TICK_LIMIT) return 16'($urandom_range(40));
				if (idx == REG_ARRIVE_TOL) return 16'($urandom_range(3000));
				return 16'($urandom_range(top));
			end
		endcase
	endfunction

	// Goal sequences: a new target, then ticks with the pose scattered around it
	// at random scales, with some stray new_target flags mixed in.
	task automatic test_random_goals(input int phases, input int per_phase);
		int sent, len, span, tx, ty;
		logic nt;
		for (int ph = 0; ph < phases; ph++) begin
			for (int r = 0; r < 7; r++)
				write_reg(r[2:0], rand_reg(r[2:0]));
			stall_mode = ph % 4;
			sent = 0;
			while (sent < per_phase) begin
				len = $urandom_range(1, 30);
				tx = int'($urandom_range(65535)) - 32768;
				ty = int'($urandom_range(65535)) - 32768;
				for (int k = 0; k < len && sent < per_phase; k++) begin
					case ($urandom_range(4))
						0: span = 32767;
						1: span = 4096;
						2: span = 400;
						default: span = 60;
					endcase
					nt = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(12) == 0);
					send_tick(make_tick(tx, ty,
						tx + int'($urandom_range(2 * span)) - span,
						ty + int'($urandom_range(2 * span)) - span,
						rand_heading(), nt));
					sent++;
				end
				// Once per phase the sender holds off until the block is empty.
				if (sent >= per_phase / 2 && sent - len < per_phase / 2) begin
					@(negedge clk);
					in_valid = 1'b0;
					while (pending_cmds.size() != 0) @(negedge clk);
				end
			end
			wait_drained();
		end
	endtask

	// The receiver stalls on a pattern chosen per phase.
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(2) == 0);
			2: out_stall <= ((stall_phase % 32) < 12);
			default: out_stall <= ($urandom_range(9) < 8);
		endcase
	end

	// Every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		motion_cmd_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("unexpected result count", 1, 0);
			end else begin
				want = pending_cmds.pop_front();
				if (linear_cmd !== want.lin)
					report_mismatch("linear_cmd", linear_cmd, want.lin);
				if (angular_cmd !== want.ang)
					report_mismatch("angular_cmd", angular_cmd, want.ang);
				if (finished !== want.fin)
					report_mismatch("finished", finished, want.fin);
				if (finish_reason !== want.reason)
					report_mismatch("finish_reason", finish_reason, want.reason);
			end
		end
	end

	// A run that hangs is cut off here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("go_to_goal_heading_controller_top regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		target_x = '0;
		target_y = '0;
		pose_x = '0;
		pose_y = '0;
		pose_heading = '0;
		new_target = 1'b0;
		out_stall = 1'b0;
		stall_mode = 0;
		stall_phase = 0;
		cycle_count = 0;
		mismatch_count = 0;
		burst_left = 0;
		ticks_used = '0;
		goal_closed = 1'b0;
		shadow_regs[REG_TURN_GAIN] = 16'd2048;
		shadow_regs[REG_DRIVE_GAIN] = 16'd3277;
		shadow_regs[REG_ARRIVE_TOL] = 16'd102;
		shadow_regs[REG_HEADING_TOL] = 16'd819;
		shadow_regs[REG_LINEAR_LIMIT] = 16'd1024;
		shadow_regs[REG_ANGULAR_LIM] = 16'd8192;
		shadow_regs[REG_TICK_LIMIT] = 16'd300;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset defaults are exercised first, then the directed corners.
		test_field_extremes();
		stall_mode = 1;
		test_tick_limit();
		test_register_extremes();
		test_random_goals(6, 150);

		wait_drained();
		if (mismatch_count == 0)
			$display("go_to_goal_heading_controller_top regression: pass");
		else
			$display("go_to_goal_heading_controller_top regression: fail");
		$finish;
	end

endmodule
